>>> src/p2c_pkg.sv
// Shared types, constants and the pixel packing function of the planar-to-chunky converter.
package p2c_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ENTRY_W  = 24;
    localparam int unsigned GROUP_W  = 32;
    localparam int unsigned BPP_W    = 8;
    localparam int unsigned ROWS_W   = 11;
    localparam int unsigned ROW_IDX_W = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned PLANE_W  = 2;
    localparam int unsigned LANES    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PLANE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 2'd1;

    // Plane codes.
    localparam logic [PLANE_W-1:0] PLANE_0 = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_1 = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_2 = 2'd2;
    localparam logic [PLANE_W-1:0] PLANE_3 = 2'd3;

    localparam logic [BPP_W-1:0]  RESET_BPP  = 8'd40;
    localparam logic [ROWS_W-1:0] RESET_ROWS = 11'd200;
    localparam logic [ROWS_W-1:0] ROW_LIMIT  = 11'd1024;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [GROUP_W-1:0] t_group;

    // Row store access issued for one accepted request.
    typedef struct packed {
        logic             rd_en;
        logic [LANES-1:0] lane_we;
        t_entry           wr_data;
    } t_store_req;

    // A plane-3 request that produces a pixel group.
    typedef struct packed {
        logic valid;
        logic row_end;
        logic image_end;
    } t_grp_req;

    // Eight 4-bit pixels from planes 0..2 (entry) and plane 3; leftmost pixel on top.
    function automatic t_group pack_pixels(input t_entry entry, input t_byte b3);
        t_group res;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            res[4*i+0] = entry[i];
            res[4*i+1] = entry[8+i];
            res[4*i+2] = entry[16+i];
            res[4*i+3] = b3[i];
        end
        return res;
    endfunction

endpackage

>>> src/planar_to_chunky_row_converter.sv
// Top level of the planar-to-chunky row converter.
//
// Takes one planar byte per cycle while o_in_ready is high; each row arrives as planes 0 to 3
// of bytes_per_plane bytes. Planes 0 to 2 are written into a single-port row store, and each
// plane-3 byte reads its entry and yields one 32-bit group of eight 4-bit pixels, leftmost
// pixel in bits 31..28, with row_end and image_end flags. Throughput is one byte per cycle
// while the input is not stalled. A taken plane-3 byte is registered in the read stage, where
// the store read lands, and the group is then packed into the output register. Output
// backpressure stalls every input byte once both the read stage and the output register hold
// a group. Store entries need no clearing after reset, since every entry is written before
// it is read.
module planar_to_chunky_row_converter #(
    parameter int unsigned MAX_BYTES_PER_PLANE = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [p2c_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [p2c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_planar_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_pixel_group,
    output logic                           o_row_end,
    output logic                           o_image_end
);
    import p2c_pkg::*;

    localparam int unsigned ADDR_W =
        (MAX_BYTES_PER_PLANE > 1) ? $clog2(MAX_BYTES_PER_PLANE) : 1;

    logic              w_accept;
    t_store_req        w_store_req;
    logic [ADDR_W-1:0] w_addr;
    t_grp_req          w_grp;
    t_entry            w_entry;

    assign w_accept = i_in_valid && o_in_ready;

    p2c_ctrl #(
        .MAX_BYTES_PER_PLANE (MAX_BYTES_PER_PLANE),
        .ADDR_W              (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_byte      (i_planar_byte),
        .o_store_req (w_store_req),
        .o_addr      (w_addr),
        .o_grp       (w_grp)
    );

    p2c_store #(
        .MAX_BYTES_PER_PLANE (MAX_BYTES_PER_PLANE),
        .ADDR_W              (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (w_store_req),
        .i_addr    (w_addr),
        .o_rd_data (w_entry)
    );

    p2c_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grp         (w_grp),
        .i_byte        (i_planar_byte),
        .i_entry       (w_entry),
        .o_take        (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_group (o_pixel_group),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end)
    );

endmodule

>>> src/p2c_ctrl.sv
// Plane, byte and row counters, configuration registers and row store request generation.
module p2c_ctrl #(
    parameter int unsigned MAX_BYTES_PER_PLANE = 128,
    parameter int unsigned ADDR_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [p2c_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [p2c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  p2c_pkg::t_byte                i_byte,
    output p2c_pkg::t_store_req           o_store_req,
    output logic [ADDR_W-1:0]             o_addr,
    output p2c_pkg::t_grp_req             o_grp
);
    import p2c_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BYTES_PER_PLANE + 1);
    localparam int unsigned CMP_W = (CNT_W > BPP_W) ? CNT_W : BPP_W;

    logic [BPP_W-1:0]     r_bpp;
    logic [ROWS_W-1:0]    r_rows;
    logic [PLANE_W-1:0]   r_plane, n_plane;
    logic [ADDR_W-1:0]    r_byte_idx, n_byte_idx;
    logic [ROW_IDX_W-1:0] r_row_idx, n_row_idx;

    logic [CMP_W-1:0]  w_bpp_ext;
    logic [CMP_W-1:0]  w_eff_bytes;
    logic [CMP_W-1:0]  w_next_byte;
    logic [ROWS_W-1:0] w_eff_rows;
    logic [ROWS_W-1:0] w_next_row;
    logic              w_plane_done;
    logic              w_img_done;

    always_comb begin
        w_bpp_ext = CMP_W'(r_bpp);
        if (r_bpp == '0) begin
            w_eff_bytes = CMP_W'(1);
        end else if (w_bpp_ext > CMP_W'(MAX_BYTES_PER_PLANE)) begin
            w_eff_bytes = CMP_W'(MAX_BYTES_PER_PLANE);
        end else begin
            w_eff_bytes = w_bpp_ext;
        end

        if (r_rows == '0) begin
            w_eff_rows = ROWS_W'(1);
        end else if (r_rows > ROW_LIMIT) begin
            w_eff_rows = ROW_LIMIT;
        end else begin
            w_eff_rows = r_rows;
        end

        w_next_byte  = CMP_W'(r_byte_idx) + CMP_W'(1);
        w_plane_done = (w_next_byte >= w_eff_bytes);
        w_next_row   = ROWS_W'(r_row_idx) + ROWS_W'(1);
        w_img_done   = w_plane_done && (w_next_row >= w_eff_rows);
    end

    // Plane 0 starts a fresh entry, planes 1 and 2 fill their own byte lane.
    always_comb begin
        o_store_req = '0;
        o_grp       = '0;
        unique case (r_plane)
            PLANE_0: begin
                o_store_req.lane_we = {LANES{i_accept}};
                o_store_req.wr_data = {16'h0000, i_byte};
            end
            PLANE_1: begin
                o_store_req.lane_we = {1'b0, i_accept, 1'b0};
                o_store_req.wr_data = {8'h00, i_byte, 8'h00};
            end
            PLANE_2: begin
                o_store_req.lane_we = {i_accept, 2'b00};
                o_store_req.wr_data = {i_byte, 16'h0000};
            end
            PLANE_3: begin
                o_store_req.rd_en = i_accept;
                o_grp.valid       = i_accept;
                o_grp.row_end     = w_plane_done;
                o_grp.image_end   = w_img_done;
            end
            default: begin
                o_store_req = '0;
            end
        endcase
    end

    assign o_addr = r_byte_idx;

    always_comb begin
        n_plane    = r_plane;
        n_byte_idx = r_byte_idx;
        n_row_idx  = r_row_idx;
        if (i_accept) begin
            if (w_plane_done) begin
                n_byte_idx = '0;
                n_plane    = r_plane + PLANE_W'(1);
                if (r_plane == PLANE_3) begin
                    n_row_idx = w_img_done ? '0 : w_next_row[ROW_IDX_W-1:0];
                end
            end else begin
                n_byte_idx = w_next_byte[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane    <= PLANE_0;
            r_byte_idx <= '0;
            r_row_idx  <= '0;
            r_bpp      <= RESET_BPP;
            r_rows     <= RESET_ROWS;
        end else begin
            r_plane    <= n_plane;
            r_byte_idx <= n_byte_idx;
            r_row_idx  <= n_row_idx;
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_BYTES_PER_PLANE) begin
                    r_bpp <= i_cfg_data[BPP_W-1:0];
                end else if (i_cfg_index == CFG_ROW_COUNT) begin
                    r_rows <= i_cfg_data[ROWS_W-1:0];
                end
            end
        end
    end

endmodule

>>> src/p2c_store.sv
// Row store: one 24-bit entry per byte position with per-plane byte lane writes.
module p2c_store #(
    parameter int unsigned MAX_BYTES_PER_PLANE = 128,
    parameter int unsigned ADDR_W = 7
) (
    input  logic                i_clk,
    input  p2c_pkg::t_store_req i_req,
    input  logic [ADDR_W-1:0]   i_addr,
    output p2c_pkg::t_entry     o_rd_data
);
    import p2c_pkg::*;

    t_entry r_mem [MAX_BYTES_PER_PLANE];
    t_entry r_rd_data;

    // Each lane is written on its own; lanes that are not enabled keep their bits.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_req.lane_we[l]) begin
                r_mem[i_addr][8*l +: 8] <= i_req.wr_data[8*l +: 8];
            end
        end
    end

    // The read data holds until the next plane-3 request, so a stalled group keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/p2c_pack.sv
// Merge stage and output register: combines the stored planes with plane 3 into a pixel group.
module p2c_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  p2c_pkg::t_grp_req i_grp,
    input  p2c_pkg::t_byte    i_byte,
    input  p2c_pkg::t_entry   i_entry,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output p2c_pkg::t_group   o_pixel_group,
    output logic              o_row_end,
    output logic              o_image_end
);
    import p2c_pkg::*;

    logic   r_s1_valid, n_s1_valid;
    t_byte  r_s1_byte;
    logic   r_s1_row_end;
    logic   r_s1_img_end;
    logic   r_out_valid, n_out_valid;
    t_group r_out_group;
    logic   r_out_row_end;
    logic   r_out_img_end;
    logic   w_out_free;
    logic   w_s1_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_take     = w_s1_free;

    always_comb begin
        n_s1_valid  = w_s1_free ? i_grp.valid : r_s1_valid;
        n_out_valid = w_out_free ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_grp.valid) begin
            r_s1_byte    <= i_byte;
            r_s1_row_end <= i_grp.row_end;
            r_s1_img_end <= i_grp.image_end;
        end
        if (w_out_free && r_s1_valid) begin
            r_out_group   <= pack_pixels(i_entry, r_s1_byte);
            r_out_row_end <= r_s1_row_end;
            r_out_img_end <= r_s1_img_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_group = r_out_group;
    assign o_row_end     = r_out_row_end;
    assign o_image_end   = r_out_img_end;

endmodule

>>> src/p2c_checker.sv
// Port-level checks of the planar-to-chunky converter and their binding to the top level.
module p2c_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pixel_group,
    input logic        o_row_end,
    input logic        o_image_end
);

    // A stalled group keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_group))
        else $error("pixel group changed while stalled");

    // The last group of an image is always the last of its row.
    a_image_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_end |-> o_row_end)
        else $error("image end without row end");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A fresh group follows an accepted request.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("group without a preceding request");

endmodule

bind planar_to_chunky_row_converter p2c_checker u_p2c_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_group (o_pixel_group),
    .o_row_end     (o_row_end),
    .o_image_end   (o_image_end)
);
